@@ src/touchpad_gesture_binder_defines.svh @@
`ifndef TOUCHPAD_GESTURE_BINDER_DEFINES_SVH
`define TOUCHPAD_GESTURE_BINDER_DEFINES_SVH

// same-cycle implication, reset-qualified
`define TGB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touchpad_gesture_binder: same-cycle check failed");

// next-cycle implication, reset-qualified
`define TGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touchpad_gesture_binder: next-cycle check failed");

`endif

@@ src/tgb_pkg.sv @@
package tgb_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_END    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4,
        DIR_IN    = 3'd5,
        DIR_OUT   = 3'd6
    } dir_t;

    localparam logic [1:0] KIND_SWIPE = 2'd0;
    localparam logic [1:0] KIND_PINCH = 2'd1;

    localparam logic [15:0] SCALE_ONE = 16'd4096;

    localparam logic [2:0] REG_BINDING_ENABLED = 3'd0;
    localparam logic [2:0] REG_BIND_COUNT      = 3'd1;
    localparam logic [2:0] REG_BIND_TABLE      = 3'd2;
    localparam logic [2:0] REG_PINCH_OUT       = 3'd3;
    localparam logic [2:0] REG_PINCH_IN        = 3'd4;

    localparam logic [15:0] PINCH_OUT_RESET = 16'd4505;
    localparam logic [15:0] PINCH_IN_RESET  = 16'd3687;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         fingers;
        logic               claimable;
        logic               was_cancelled;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [15:0]        pinch_scale;
    } item_t;

    typedef struct packed {
        logic       use_dir;
        logic [1:0] kind;
        logic [3:0] fingers;
        dir_t       dir;
    } match_req_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] index;
    } match_rsp_t;

    typedef struct packed {
        logic       active;
        logic [1:0] kind;
        logic [3:0] fingers;
        dir_t       dir;
    } track_t;

endpackage

@@ src/tgb_matcher.sv @@
module tgb_matcher
    import tgb_pkg::*;
#(
    parameter int BIND_SLOTS = 8
)
(
    input  logic       [3:0]  bind_count,
    input  logic       [63:0] bind_table,
    input  match_req_t        req,
    output match_rsp_t        rsp
);

    logic [7:0] entry;

    always_comb
    begin
        rsp   = '0;
        entry = '0;
        for (int i = BIND_SLOTS - 1; i >= 0; i--)
        begin
            entry = bind_table[8*i +: 8];
            if ((4'(i) < bind_count) &&
                ({1'b0, entry[0]} == req.kind) &&
                (entry[4:1] == req.fingers) &&
                (!req.use_dir || (entry[7:5] == req.dir)))
            begin
                rsp.hit   = 1'b1;
                rsp.index = 3'(i);
            end
        end
    end

endmodule

@@ src/tgb_tracker.sv @@
module tgb_tracker
    import tgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  cmd_t        cmd,
    input  item_t       item,
    input  logic        claim,
    input  logic [15:0] pinch_out_threshold,
    input  logic [15:0] pinch_in_threshold,
    output track_t      trk
);

    logic               active_reg,  active_next;
    logic [1:0]         kind_reg,    kind_next;
    logic [3:0]         fingers_reg, fingers_next;
    logic signed [31:0] sum_x_reg,   sum_x_next;
    logic signed [31:0] sum_y_reg,   sum_y_next;
    logic [15:0]        scale_reg,   scale_next;

    logic        own;
    logic [32:0] add_x, add_y;
    logic [31:0] abs_x, abs_y;
    dir_t        dir;

    function automatic logic [31:0] sat32(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31])
            r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            r = s[31:0];
        return r;
    endfunction

    assign own   = active_reg && (kind_reg == item.kind);
    assign add_x = {sum_x_reg[31], sum_x_reg} + {{17{item.delta_x[15]}}, item.delta_x};
    assign add_y = {sum_y_reg[31], sum_y_reg} + {{17{item.delta_y[15]}}, item.delta_y};
    assign abs_x = sum_x_reg[31] ? 32'(-sum_x_reg) : sum_x_reg;
    assign abs_y = sum_y_reg[31] ? 32'(-sum_y_reg) : sum_y_reg;

    always_comb
    begin
        dir = DIR_NONE;
        if (kind_reg == KIND_SWIPE)
        begin
            if ((sum_x_reg == 32'sd0) && (sum_y_reg == 32'sd0))
                dir = DIR_NONE;
            else if (abs_x > abs_y)
                dir = sum_x_reg[31] ? DIR_LEFT : DIR_RIGHT;
            else
                dir = (sum_y_reg > 32'sd0) ? DIR_DOWN : DIR_UP;
        end
        else if (kind_reg == KIND_PINCH)
        begin
            if (scale_reg > pinch_out_threshold)
                dir = DIR_OUT;
            else if (scale_reg < pinch_in_threshold)
                dir = DIR_IN;
        end
    end

    assign trk = '{active: active_reg, kind: kind_reg, fingers: fingers_reg, dir: dir};

    always_comb
    begin
        active_next  = active_reg;
        kind_next    = kind_reg;
        fingers_next = fingers_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        scale_next   = scale_reg;
        if (take)
        begin
            unique case (cmd)
                CMD_BEGIN:
                begin
                    active_next  = claim;
                    kind_next    = claim ? item.kind : 2'd0;
                    fingers_next = claim ? item.fingers : 4'd0;
                    sum_x_next   = '0;
                    sum_y_next   = '0;
                    scale_next   = claim ? SCALE_ONE : 16'd0;
                end
                CMD_UPDATE:
                begin
                    if (own)
                    begin
                        sum_x_next = sat32(add_x);
                        sum_y_next = sat32(add_y);
                        if (item.kind == KIND_PINCH)
                            scale_next = item.pinch_scale;
                    end
                end
                CMD_END:
                begin
                    if (own)
                    begin
                        active_next  = 1'b0;
                        kind_next    = '0;
                        fingers_next = '0;
                        sum_x_next   = '0;
                        sum_y_next   = '0;
                        scale_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            kind_reg    <= '0;
            fingers_reg <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            scale_reg   <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            kind_reg    <= kind_next;
            fingers_reg <= fingers_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            scale_reg   <= scale_next;
        end
    end

endmodule

@@ src/touchpad_gesture_binder.sv @@
// Channel   Dir  Signals                       Accepted when
// ------------------------------------------------------------------------
// s_*       in   s_tvalid s_tready s_tdata s_tuser  s_tvalid && s_tready
// m_*       out  m_tvalid m_tready m_tdata          m_tvalid && m_tready
// apb       in   psel penable pwrite paddr pwdata   psel && penable && pwrite
//
// One item per cycle while s_tready is high; a result appears in the cycle after its item is taken.
// The tracker update, table compare and direction select run in the same cycle,
// ahead of the result register.
// s_tready stays high while the result register is empty or being drained.
// rst_n clears tracker, result valid and registers to their defaults.
module touchpad_gesture_binder
    import tgb_pkg::*;
#(
    parameter int BIND_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[1:0] fingers[5:2] claimable[6] was_cancelled[7] delta_x[23:8]
    // delta_y[39:24] pinch_scale[55:40]
    input  logic [55:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0] direction[3:1] bind_found[4] bind_index[7:5]
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    `include "touchpad_gesture_binder_defines.svh"

    logic        enabled_reg;
    logic [3:0]  count_reg;
    logic [63:0] table_reg;
    logic [15:0] pout_reg;
    logic [15:0] pin_reg;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg,  m_tdata_next;

    logic       take;
    logic       cfg_wr;
    cmd_t       cmd;
    item_t      item;
    track_t     trk;
    match_req_t req;
    match_rsp_t rsp;
    logic       claim;
    logic       own;
    logic       accepted;
    dir_t       dir_out;
    logic       found;
    logic [2:0] index;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign item     = item_t'({s_tdata[1:0], s_tdata[5:2], s_tdata[6], s_tdata[7],
                               s_tdata[23:8], s_tdata[39:24], s_tdata[55:40]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            count_reg   <= '0;
            table_reg   <= '0;
            pout_reg    <= PINCH_OUT_RESET;
            pin_reg     <= PINCH_IN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_BINDING_ENABLED: enabled_reg <= pwdata[0];
                REG_BIND_COUNT:      count_reg   <= pwdata[3:0];
                REG_BIND_TABLE:      table_reg   <= pwdata;
                REG_PINCH_OUT:       pout_reg    <= pwdata[15:0];
                REG_PINCH_IN:        pin_reg     <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_BINDING_ENABLED: prdata = {63'd0, enabled_reg};
            REG_BIND_COUNT:      prdata = {60'd0, count_reg};
            REG_BIND_TABLE:      prdata = table_reg;
            REG_PINCH_OUT:       prdata = {48'd0, pout_reg};
            REG_PINCH_IN:        prdata = {48'd0, pin_reg};
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        req = '{use_dir: 1'b1, kind: trk.kind, fingers: trk.fingers, dir: trk.dir};
        if (cmd == CMD_BEGIN)
            req = '{use_dir: 1'b0, kind: item.kind, fingers: item.fingers, dir: DIR_NONE};
    end

    tgb_matcher #(
        .BIND_SLOTS (BIND_SLOTS)
    ) u_matcher (
        .bind_count (count_reg),
        .bind_table (table_reg),
        .req        (req),
        .rsp        (rsp)
    );

    assign claim = item.claimable && enabled_reg && rsp.hit;

    tgb_tracker u_tracker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .take                (take),
        .cmd                 (cmd),
        .item                (item),
        .claim               (claim),
        .pinch_out_threshold (pout_reg),
        .pinch_in_threshold  (pin_reg),
        .trk                 (trk)
    );

    assign own = trk.active && (trk.kind == item.kind);

    always_comb
    begin
        accepted = 1'b0;
        dir_out  = DIR_NONE;
        found    = 1'b0;
        index    = '0;
        unique case (cmd)
            CMD_BEGIN:  accepted = claim;
            CMD_UPDATE: accepted = own;
            CMD_END:
            begin
                accepted = own;
                if (own && !item.was_cancelled && enabled_reg)
                begin
                    dir_out = trk.dir;
                    if ((trk.dir != DIR_NONE) && rsp.hit)
                    begin
                        found = 1'b1;
                        index = rsp.index;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (take)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {index, found, dir_out, accepted};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TGB_ASSERT_NEXT(a_take_gives_result, take, m_tvalid)
    `TGB_ASSERT_NOW(a_found_has_dir, m_tvalid && m_tdata[4],
                    m_tdata[0] && (m_tdata[3:1] != 3'd0))
    `TGB_ASSERT_NEXT(a_end_clears, take && (cmd == CMD_END) && own, !trk.active)
    `TGB_ASSERT_NOW(a_index_in_range, m_tvalid && m_tdata[4],
                    {29'd0, m_tdata[7:5]} < 32'(BIND_SLOTS))

endmodule
